FILE: rtl/windowed_dark_frame_subtract_unit_macros.svh
// Assertion macros used by the top level of the dark frame subtraction RTL.
`ifndef WINDOWED_DARK_FRAME_SUBTRACT_UNIT_MACROS_SVH
`define WINDOWED_DARK_FRAME_SUBTRACT_UNIT_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is held low.
`define WDFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is held low.
`define WDFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wdfs_pkg.sv
// Package with the constants, codes and pipeline types of the dark frame subtractor.
`timescale 1ns / 1ps

package wdfs_pkg;

    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 256;
    localparam int PIXEL_BITS = 16;
    localparam int ADDR_BITS  = 16;
    localparam int DARK_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int DIFF_BITS  = PIXEL_BITS + 1;
    localparam int CFG_BITS   = 9;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COLS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_ROWS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_WINDOW    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_COL_START = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_ROW_START = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_COL_END   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_ROW_END   = 3'd6;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_GEOM = 2'd1,
        ST_COUNT    = 2'd2
    } t_status;

    // Decoded geometry of the active area.
    typedef struct packed {
        logic       ok;
        logic [7:0] col_start;
        logic [7:0] row_start;
        logic [8:0] ncols;
        logic [8:0] nrows;
        logic [8:0] frame_cols;
    } t_geom;

    // Beat held between the counter stage and the store.
    typedef struct packed {
        logic                  valid;
        logic                  load;
        logic [ADDR_BITS-1:0]  addr;
        logic [PIXEL_BITS-1:0] pix;
        logic                  last;
        t_status               status;
        logic                  zero;
    } t_s1;

    // Beat held between the store and the output register.
    typedef struct packed {
        logic                  valid;
        logic [PIXEL_BITS-1:0] pix;
        logic [PIXEL_BITS-1:0] dark;
        logic                  last;
        t_status               status;
        logic                  zero;
    } t_s2;

endpackage

FILE: rtl/wdfs_cfg.sv
// Configuration registers and geometry decode of the dark frame subtractor.
`timescale 1ns / 1ps

module wdfs_cfg
    import wdfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    output t_geom                   o_geom
);

    logic [8:0] r_frame_cols;
    logic [8:0] r_frame_rows;
    logic       r_use_window;
    logic [7:0] r_win_col_start;
    logic [7:0] r_win_row_start;
    logic [7:0] r_win_col_end;
    logic [7:0] r_win_row_end;

    logic       w_frame_ok;
    logic       w_win_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols    <= 9'd256;
            r_frame_rows    <= 9'd256;
            r_use_window    <= 1'b0;
            r_win_col_start <= 8'd0;
            r_win_row_start <= 8'd0;
            r_win_col_end   <= 8'd255;
            r_win_row_end   <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_COLS:    r_frame_cols    <= i_cfg_data;
                CFG_FRAME_ROWS:    r_frame_rows    <= i_cfg_data;
                CFG_USE_WINDOW:    r_use_window    <= i_cfg_data[0];
                CFG_WIN_COL_START: r_win_col_start <= i_cfg_data[7:0];
                CFG_WIN_ROW_START: r_win_row_start <= i_cfg_data[7:0];
                CFG_WIN_COL_END:   r_win_col_end   <= i_cfg_data[7:0];
                CFG_WIN_ROW_END:   r_win_row_end   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_frame_ok = (r_frame_cols != 9'd0) && (r_frame_rows != 9'd0) &&
                        (r_frame_cols <= 9'(MAX_COLS)) && (r_frame_rows <= 9'(MAX_ROWS));
    assign w_win_ok   = (r_win_col_start <= r_win_col_end) &&
                        (r_win_row_start <= r_win_row_end) &&
                        ({1'b0, r_win_col_end} < r_frame_cols) &&
                        ({1'b0, r_win_row_end} < r_frame_rows);

    always_comb begin
        o_geom.frame_cols = r_frame_cols;
        if (r_use_window) begin
            o_geom.ok        = w_frame_ok && w_win_ok;
            o_geom.col_start = r_win_col_start;
            o_geom.row_start = r_win_row_start;
            o_geom.ncols     = {1'b0, r_win_col_end} - {1'b0, r_win_col_start} + 9'd1;
            o_geom.nrows     = {1'b0, r_win_row_end} - {1'b0, r_win_row_start} + 9'd1;
        end else begin
            o_geom.ok        = w_frame_ok;
            o_geom.col_start = 8'd0;
            o_geom.row_start = 8'd0;
            o_geom.ncols     = r_frame_cols;
            o_geom.nrows     = r_frame_rows;
        end
    end

endmodule

FILE: rtl/wdfs_addr.sv
// Window counters, status decision and dark store address for each accepted beat.
`timescale 1ns / 1ps

module wdfs_addr
    import wdfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_en,
    input  logic                  i_req_type,
    input  logic [15:0]           i_dark_index,
    input  logic [PIXEL_BITS-1:0] i_pixel_value,
    input  logic                  i_last_pixel,
    input  t_geom                 i_geom,
    output t_s1                   o_s1
);

    logic [7:0]  r_col;
    logic [8:0]  r_row;
    logic [7:0]  n_col;
    logic [8:0]  n_row;
    t_s1         r_s1;
    t_s1         n_s1;

    logic [8:0]  w_col_ext;
    logic [8:0]  w_col_inc;
    logic [8:0]  w_r_abs;
    logic [8:0]  w_c_abs;
    logic [17:0] w_prod;
    logic [17:0] w_sum;
    logic        w_beyond;
    logic        w_at_end;

    assign w_col_ext = {1'b0, r_col};
    assign w_col_inc = w_col_ext + 9'd1;
    assign w_beyond  = (w_col_ext >= i_geom.ncols) || (r_row >= i_geom.nrows);
    assign w_at_end  = (w_col_ext == i_geom.ncols - 9'd1) && (r_row == i_geom.nrows - 9'd1);
    assign w_r_abs   = {1'b0, i_geom.row_start} + r_row;
    assign w_c_abs   = {1'b0, i_geom.col_start} + w_col_ext;
    assign w_prod    = w_r_abs * i_geom.frame_cols;
    assign w_sum     = w_prod + {9'd0, w_c_abs};

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_s1.valid  = i_accept;
        n_s1.load   = !i_req_type;
        n_s1.pix    = i_pixel_value;
        n_s1.last   = i_last_pixel;
        n_s1.addr   = i_dark_index;
        n_s1.status = ST_OK;
        n_s1.zero   = 1'b0;
        if (i_req_type) begin
            n_s1.addr = w_sum[ADDR_BITS-1:0];
            if (!i_geom.ok) begin
                n_s1.status = ST_BAD_GEOM;
                n_s1.zero   = 1'b1;
            end else if (w_beyond) begin
                n_s1.status = ST_COUNT;
                n_s1.zero   = 1'b1;
            end else begin
                if (i_last_pixel && !w_at_end) begin
                    n_s1.status = ST_COUNT;
                end
                if (w_col_inc >= i_geom.ncols) begin
                    n_col = 8'd0;
                    n_row = r_row + 9'd1;
                end else begin
                    n_col = w_col_inc[7:0];
                end
            end
            // Any marked last subtract pixel restarts the frame.
            if (i_last_pixel) begin
                n_col = 8'd0;
                n_row = 9'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.load   <= n_s1.load;
            r_s1.addr   <= n_s1.addr;
            r_s1.pix    <= n_s1.pix;
            r_s1.last   <= n_s1.last;
            r_s1.status <= n_s1.status;
            r_s1.zero   <= n_s1.zero;
        end
        if (!i_rst_n) begin
            r_col       <= 8'd0;
            r_row       <= 9'd0;
            r_s1.valid  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_en) begin
                r_s1.valid <= n_s1.valid;
            end
        end
    end

    assign o_s1 = r_s1;

endmodule

FILE: rtl/wdfs_store.sv
// Dark frame memory: writes load beats and reads the dark pixel for subtract beats.
`timescale 1ns / 1ps

module wdfs_store
    import wdfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    logic [PIXEL_BITS-1:0] mem [DARK_DEPTH];
    t_s2                   r_s2;

    always_ff @(posedge i_clk) begin
        if (i_en && i_s1.valid && i_s1.load) begin
            mem[i_s1.addr] <= i_s1.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_s1.valid && !i_s1.load) begin
                r_s2.dark <= mem[i_s1.addr];
            end
            r_s2.pix    <= i_s1.pix;
            r_s2.last   <= i_s1.last;
            r_s2.status <= i_s1.status;
            r_s2.zero   <= i_s1.zero;
        end
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2.valid <= i_s1.valid && !i_s1.load;
        end
    end

    assign o_s2 = r_s2;

endmodule

FILE: rtl/windowed_dark_frame_subtract_unit.sv
// Top level of the windowed dark frame subtractor.
// A subtract beat passes the first-stage, store and output registers before it shows at the output.
// Throughput: one beat per cycle while the output is not stalled; the single-port dark memory does one access per beat.
// The whole pipeline holds only while a result waits untaken in the output register.
// Synchronous active-low reset clears the counters, pipeline valids and configuration;
// the dark memory is not cleared and must be loaded before it is read.
`timescale 1ns / 1ps
`include "windowed_dark_frame_subtract_unit_macros.svh"

module windowed_dark_frame_subtract_unit
    import wdfs_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input beat channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [15:0]                 i_dark_index,
    input  logic [PIXEL_BITS-1:0]       i_pixel_value,
    input  logic                        i_last_pixel,
    // Result beat channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DIFF_BITS-1:0] o_corrected_value,
    output logic [1:0]                  o_status,
    output logic                        o_frame_done,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_BITS-1:0]         i_cfg_data
);

    t_geom                 w_geom;
    t_s1                   w_s1;
    t_s2                   w_s2;
    logic                  w_en;
    logic                  w_accept;
    logic [DIFF_BITS-1:0]  n_value;

    logic                  r_out_valid;
    logic [DIFF_BITS-1:0]  r_value;
    t_status               r_status;
    logic                  r_done;

    logic                  w_load_step;
    logic                  w_bad_out;

    // The pipeline moves whenever the output register is empty or being drained,
    // so a new beat is taken even while a finished result is still on offer.
    assign w_en       = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && w_en;
    assign o_in_ready = w_en;

    wdfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom)
    );

    // First stage: window counters, status and the memory address.
    wdfs_addr u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_en          (w_en),
        .i_req_type    (i_req_type),
        .i_dark_index  (i_dark_index),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .i_geom        (w_geom),
        .o_s1          (w_s1)
    );

    // Second stage: dark memory write or registered read. Loads end here.
    wdfs_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_s1    (w_s1),
        .o_s2    (w_s2)
    );

    // Third stage: the difference is exact in one extra bit, so no clamping is done.
    // Beats with bad geometry or beyond the area give zero.
    always_comb begin
        if (w_s2.zero) begin
            n_value = '0;
        end else begin
            n_value = {1'b0, w_s2.pix} - {1'b0, w_s2.dark};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value  <= n_value;
            r_status <= w_s2.status;
            r_done   <= w_s2.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_corrected_value = signed'(r_value);
    assign o_status          = r_status;
    assign o_frame_done      = r_done;

    // A load beat leaving the first stage, and a bad geometry result on offer.
    assign w_load_step = w_en && w_s1.valid && w_s1.load;
    assign w_bad_out   = r_out_valid && (r_status == ST_BAD_GEOM);

    // A load never produces a result beat.
    `WDFS_ASSERT_NEXT(a_load_no_result, w_load_step, !w_s2.valid, "load beat gave a result")
    // A beat with bad geometry always carries a zero value.
    `WDFS_ASSERT_IMPL(a_bad_geom_zero, w_bad_out, r_value == '0, "bad geometry result not zero")
    // While the output stalls, the store stage keeps its beat.
    `WDFS_ASSERT_NEXT(a_stall_holds, !w_en, $stable({w_s2, w_s1.valid}), "stall moved the pipe")

endmodule
